>>> hdl/raibert_footstep_placement_defines.svh
// Assertion macros used by the footstep placement top level.
`ifndef RAIBERT_FOOTSTEP_PLACEMENT_DEFINES_SVH
`define RAIBERT_FOOTSTEP_PLACEMENT_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define RFP_ASSERT_NOW(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |-> (effect)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define RFP_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

>>> hdl/rfp_pkg.sv
// Types, constants and helpers for the footstep placement pipeline.
package rfp_pkg;

    localparam int NUM_FEET = 4;
    localparam int IN_W     = 384;
    localparam int OUT_W    = 128;
    localparam int CFG_W    = 18;
    localparam int IDX_W    = 3;

    localparam logic [1:0] LAST_FOOT = 2'(NUM_FEET - 1);

    // Feet with a negative hip offset along x (rear) and along y (right).
    localparam logic [NUM_FEET-1:0] FOOT_NEG_X = 4'b1100;
    localparam logic [NUM_FEET-1:0] FOOT_NEG_Y = 4'b1010;

    localparam logic [IDX_W-1:0] CFG_HIP_X     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HIP_Y     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_STANCE    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_VEL_GAIN  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CENT_GAIN = 3'd4;

    localparam logic [16:0] RST_HIP_X     = 17'd12327;
    localparam logic [16:0] RST_HIP_Y     = 17'd8307;
    localparam logic [17:0] RST_STANCE    = 18'd32768;
    localparam logic [17:0] RST_VEL_GAIN  = 18'd1966;
    localparam logic [17:0] RST_CENT_GAIN = 18'd6617;

    localparam logic signed [54:0] WIDE_MAX = 55'sd2147483647;
    localparam logic signed [54:0] WIDE_MIN = -55'sd2147483648;

    typedef struct packed {
        logic [16:0] hip_x;
        logic [16:0] hip_y;
        logic [17:0] stance_gain;
        logic [17:0] vel_gain;
        logic [17:0] cent_gain;
    } t_cfg;

    // Rotation entries, cross product and gain products after stage two.
    typedef struct packed {
        logic signed [33:0] r00;
        logic signed [33:0] r01;
        logic signed [33:0] r10;
        logic signed [33:0] r11;
        logic signed [48:0] crs_x;
        logic signed [48:0] crs_y;
        logic signed [50:0] sg_x;
        logic signed [50:0] sg_y;
        logic signed [51:0] vg_x;
        logic signed [51:0] vg_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_s2;

    // Rounded hip offsets per foot and per-item step terms after stage four.
    typedef struct packed {
        logic [NUM_FEET-1:0][26:0] hoff_x;
        logic [NUM_FEET-1:0][26:0] hoff_y;
        logic signed [36:0] sym_x;
        logic signed [36:0] sym_y;
        logic signed [52:0] cen_x;
        logic signed [52:0] cen_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_s4;

    function automatic logic [31:0] sat32(input logic signed [54:0] v);
        logic [31:0] res;
        if (v > WIDE_MAX) begin
            res = 32'h7FFF_FFFF;
        end else if (v < WIDE_MIN) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

>>> hdl/rfp_front.sv
// Stages one and two: quaternion and velocity products, rotation entries.
module rfp_front import rfp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [IN_W-1:0] i_data,
    input  t_cfg            i_cfg,
    output logic            o_valid,
    output t_s2             o_s2
);

    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

    logic signed [31:0] w_pos_x, w_pos_y;
    logic signed [15:0] w_qx, w_qy, w_qz, w_qw;
    logic signed [31:0] w_vel_x, w_vel_y, w_vel_z;
    logic signed [31:0] w_cmd_x, w_cmd_y;
    logic signed [31:0] w_rate_x, w_rate_y, w_rate_z;
    logic signed [18:0] w_sg, w_vg;

    assign w_pos_x  = i_data[31:0];
    assign w_pos_y  = i_data[63:32];
    assign w_qx     = i_data[127:112];
    assign w_qy     = i_data[111:96];
    assign w_qz     = i_data[95:80];
    assign w_qw     = i_data[79:64];
    assign w_vel_x  = i_data[159:128];
    assign w_vel_y  = i_data[191:160];
    assign w_vel_z  = i_data[223:192];
    assign w_cmd_x  = i_data[255:224];
    assign w_cmd_y  = i_data[287:256];
    assign w_rate_x = i_data[319:288];
    assign w_rate_y = i_data[351:320];
    assign w_rate_z = i_data[383:352];
    assign w_sg     = {1'b0, i_cfg.stance_gain};
    assign w_vg     = {1'b0, i_cfg.vel_gain};

    // Stage one
    logic               r_s1_valid;
    logic signed [31:0] r_s1_qxy, r_s1_qwz, r_s1_qxx, r_s1_qyy, r_s1_qzz;
    logic signed [63:0] r_s1_cxa, r_s1_cxb, r_s1_cya, r_s1_cyb;
    logic signed [50:0] r_s1_sg_x, r_s1_sg_y;
    logic signed [32:0] r_s1_ev_x, r_s1_ev_y;
    logic signed [31:0] r_s1_pos_x, r_s1_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_qxy   <= 32'(w_qx) * 32'(w_qy);
            r_s1_qwz   <= 32'(w_qw) * 32'(w_qz);
            r_s1_qxx   <= 32'(w_qx) * 32'(w_qx);
            r_s1_qyy   <= 32'(w_qy) * 32'(w_qy);
            r_s1_qzz   <= 32'(w_qz) * 32'(w_qz);
            r_s1_cxa   <= 64'(w_vel_y) * 64'(w_rate_z);
            r_s1_cxb   <= 64'(w_vel_z) * 64'(w_rate_y);
            r_s1_cya   <= 64'(w_vel_z) * 64'(w_rate_x);
            r_s1_cyb   <= 64'(w_vel_x) * 64'(w_rate_z);
            r_s1_sg_x  <= 51'(w_sg) * 51'(w_vel_x);
            r_s1_sg_y  <= 51'(w_sg) * 51'(w_vel_y);
            r_s1_ev_x  <= 33'(w_vel_x) - 33'(w_cmd_x);
            r_s1_ev_y  <= 33'(w_vel_y) - 33'(w_cmd_y);
            r_s1_pos_x <= w_pos_x;
            r_s1_pos_y <= w_pos_y;
        end
    end

    // Stage two: rotation entries in Q6.28, cross product rounded to Q33.16
    logic signed [64:0] w_dx, w_dy;
    logic signed [33:0] w_yy_zz, w_xx_zz, w_xy_m_wz, w_xy_p_wz;
    logic               r_s2_valid;
    t_s2                r_s2;

    assign w_yy_zz   = 34'(r_s1_qyy) + 34'(r_s1_qzz);
    assign w_xx_zz   = 34'(r_s1_qxx) + 34'(r_s1_qzz);
    assign w_xy_m_wz = 34'(r_s1_qxy) - 34'(r_s1_qwz);
    assign w_xy_p_wz = 34'(r_s1_qxy) + 34'(r_s1_qwz);
    assign w_dx      = 65'(r_s1_cxa) - 65'(r_s1_cxb) + 65'sd32768;
    assign w_dy      = 65'(r_s1_cya) - 65'(r_s1_cyb) + 65'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2.r00   <= ONE_Q28 - (w_yy_zz <<< 1);
            r_s2.r01   <= w_xy_m_wz <<< 1;
            r_s2.r10   <= w_xy_p_wz <<< 1;
            r_s2.r11   <= ONE_Q28 - (w_xx_zz <<< 1);
            r_s2.crs_x <= w_dx[64:16];
            r_s2.crs_y <= w_dy[64:16];
            r_s2.sg_x  <= r_s1_sg_x;
            r_s2.sg_y  <= r_s1_sg_y;
            r_s2.vg_x  <= 52'(w_vg) * 52'(r_s1_ev_x);
            r_s2.vg_y  <= 52'(w_vg) * 52'(r_s1_ev_y);
            r_s2.pos_x <= r_s1_pos_x;
            r_s2.pos_y <= r_s1_pos_y;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_s2    = r_s2;

endmodule

>>> hdl/rfp_back.sv
// Stages three and four: hip offset rotation, symmetry and centrifugal terms.
module rfp_back import rfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_s2  i_s2,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_s4  o_s4
);

    logic signed [17:0] w_hx, w_hy;
    logic signed [18:0] w_kg;
    logic signed [52:0] w_sy_x, w_sy_y;

    assign w_hx   = {1'b0, i_cfg.hip_x};
    assign w_hy   = {1'b0, i_cfg.hip_y};
    assign w_kg   = {1'b0, i_cfg.cent_gain};
    assign w_sy_x = 53'(i_s2.sg_x) + 53'(i_s2.vg_x) + 53'sd32768;
    assign w_sy_y = 53'(i_s2.sg_y) + 53'(i_s2.vg_y) + 53'sd32768;

    // Stage three
    logic               r_s3_valid;
    logic signed [51:0] r_s3_a, r_s3_b, r_s3_c, r_s3_d;
    logic signed [36:0] r_s3_sym_x, r_s3_sym_y;
    logic signed [51:0] r_s3_gch_x, r_s3_gch_y;
    logic [33:0]        r_s3_gcl_x, r_s3_gcl_y;
    logic signed [31:0] r_s3_pos_x, r_s3_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_valid;
        end
    end

    // Hip products, symmetry term, gain product split by cross term halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_a     <= 52'(i_s2.r00) * 52'(w_hx);
            r_s3_b     <= 52'(i_s2.r01) * 52'(w_hy);
            r_s3_c     <= 52'(i_s2.r10) * 52'(w_hx);
            r_s3_d     <= 52'(i_s2.r11) * 52'(w_hy);
            r_s3_sym_x <= w_sy_x[52:16];
            r_s3_sym_y <= w_sy_y[52:16];
            r_s3_gch_x <= 52'(w_kg) * 52'($signed(i_s2.crs_x[48:16]));
            r_s3_gch_y <= 52'(w_kg) * 52'($signed(i_s2.crs_y[48:16]));
            r_s3_gcl_x <= 34'(i_cfg.cent_gain) * 34'(i_s2.crs_x[15:0]);
            r_s3_gcl_y <= 34'(i_cfg.cent_gain) * 34'(i_s2.crs_y[15:0]);
            r_s3_pos_x <= i_s2.pos_x;
            r_s3_pos_y <= i_s2.pos_y;
        end
    end

    // Stage four: per-foot signed offsets rounded from Q.28
    logic signed [54:0] w_sx [NUM_FEET];
    logic signed [54:0] w_sy [NUM_FEET];
    logic [34:0]        w_lo_x, w_lo_y;
    logic               r_s4_valid;
    t_s4                r_s4;

    always_comb begin
        for (int k = 0; k < NUM_FEET; k++) begin
            w_sx[k] = (FOOT_NEG_X[k] ? -55'(r_s3_a) : 55'(r_s3_a))
                    + (FOOT_NEG_Y[k] ? -55'(r_s3_b) : 55'(r_s3_b))
                    + 55'sd134217728;
            w_sy[k] = (FOOT_NEG_X[k] ? -55'(r_s3_c) : 55'(r_s3_c))
                    + (FOOT_NEG_Y[k] ? -55'(r_s3_d) : 55'(r_s3_d))
                    + 55'sd134217728;
        end
    end

    assign w_lo_x = {1'b0, r_s3_gcl_x} + 35'd32768;
    assign w_lo_y = {1'b0, r_s3_gcl_y} + 35'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_FEET; k++) begin
                r_s4.hoff_x[k] <= w_sx[k][54:28];
                r_s4.hoff_y[k] <= w_sy[k][54:28];
            end
            r_s4.sym_x <= r_s3_sym_x;
            r_s4.sym_y <= r_s3_sym_y;
            r_s4.cen_x <= 53'(r_s3_gch_x) + $signed({34'd0, w_lo_x[34:16]});
            r_s4.cen_y <= 53'(r_s3_gch_y) + $signed({34'd0, w_lo_y[34:16]});
            r_s4.pos_x <= r_s3_pos_x;
            r_s4.pos_y <= r_s3_pos_y;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_s4    = r_s4;

endmodule

>>> hdl/rfp_emit.sv
// Per-item buffer that walks the four feet, with the registered result stage.
module rfp_emit import rfp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_s4              i_s4,
    output logic             o_take,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [OUT_W-1:0] o_tdata,
    output logic [1:0]       o_tuser,
    output logic             o_tlast
);

    logic                      r_sr_valid;
    logic [1:0]                r_sr_cnt;
    logic [NUM_FEET-1:0][33:0] r_sr_hip_x, r_sr_hip_y;
    logic signed [53:0]        r_sr_sc_x, r_sr_sc_y;

    logic                      r_o_valid;
    logic [1:0]                r_o_foot;
    logic                      r_o_last;
    logic [31:0]               r_o_hip_x, r_o_hip_y, r_o_step_x, r_o_step_y;

    logic                      w_o_load, w_emit, w_done;
    logic [NUM_FEET-1:0][33:0] n_hip_x, n_hip_y;
    logic signed [33:0]        w_hip_x, w_hip_y;
    logic signed [54:0]        w_step_x, w_step_y;

    assign w_o_load = !r_o_valid || i_tready;
    assign w_emit   = r_sr_valid && w_o_load;
    assign w_done   = w_emit && (r_sr_cnt == LAST_FOOT);
    assign o_take   = !r_sr_valid || w_done;

    always_comb begin
        for (int k = 0; k < NUM_FEET; k++) begin
            n_hip_x[k] = 34'(i_s4.pos_x) + 34'($signed(i_s4.hoff_x[k]));
            n_hip_y[k] = 34'(i_s4.pos_y) + 34'($signed(i_s4.hoff_y[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr_valid <= 1'b0;
            r_sr_cnt   <= 2'd0;
        end else if (o_take) begin
            r_sr_valid <= i_valid;
            r_sr_cnt   <= 2'd0;
        end else if (w_emit) begin
            r_sr_cnt   <= r_sr_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_sr_hip_x <= n_hip_x;
            r_sr_hip_y <= n_hip_y;
            r_sr_sc_x  <= 54'(i_s4.sym_x) + 54'(i_s4.cen_x);
            r_sr_sc_y  <= 54'(i_s4.sym_y) + 54'(i_s4.cen_y);
        end
    end

    assign w_hip_x  = $signed(r_sr_hip_x[r_sr_cnt]);
    assign w_hip_y  = $signed(r_sr_hip_y[r_sr_cnt]);
    assign w_step_x = 55'(w_hip_x) + 55'(r_sr_sc_x);
    assign w_step_y = 55'(w_hip_y) + 55'(r_sr_sc_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_load) begin
            r_o_valid <= r_sr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_foot   <= r_sr_cnt;
            r_o_last   <= (r_sr_cnt == LAST_FOOT);
            r_o_hip_x  <= sat32(55'(w_hip_x));
            r_o_hip_y  <= sat32(55'(w_hip_y));
            r_o_step_x <= sat32(w_step_x);
            r_o_step_y <= sat32(w_step_y);
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata  = {r_o_step_y, r_o_step_x, r_o_hip_y, r_o_hip_x};
    assign o_tuser  = r_o_foot;
    assign o_tlast  = r_o_last;

endmodule

>>> hdl/raibert_footstep_placement.sv
// A pose request passes stages one to four, the foot serializer buffer and the output
// register. The four foot results of one request leave back to back when the sink is ready,
// and the serializer holds a request until its last foot goes out on the single result port.
// The four-stage arithmetic front takes a request every cycle until the foot
// serializer backs up. Reset is synchronous, active low: clears all valid bits and
// reloads the gain and hip offset registers with their defaults.
`include "raibert_footstep_placement_defines.svh"

module raibert_footstep_placement import rfp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write port, one register per index
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // Pose request stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, low to high: base_pos_x, base_pos_y, orientation, base_vel_x,
    // base_vel_y, base_vel_z, cmd_vel_x, cmd_vel_y, cmd_rate_x, cmd_rate_y,
    // cmd_rate_z
    input  logic [IN_W-1:0]  s_axis_tdata,
    // Foot result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tdata, low to high: hip_world_x, hip_world_y, step_x, step_y
    output logic [OUT_W-1:0] m_axis_tdata,
    // tuser: foot_index
    output logic [1:0]       m_axis_tuser,
    // tlast: last_foot
    output logic             m_axis_tlast
);

    // Configuration registers; user must write only while pipeline is drained; unenforced
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hip_x       <= RST_HIP_X;
            r_cfg.hip_y       <= RST_HIP_Y;
            r_cfg.stance_gain <= RST_STANCE;
            r_cfg.vel_gain    <= RST_VEL_GAIN;
            r_cfg.cent_gain   <= RST_CENT_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HIP_X:     r_cfg.hip_x       <= i_cfg_wdata[16:0];
                CFG_HIP_Y:     r_cfg.hip_y       <= i_cfg_wdata[16:0];
                CFG_STANCE:    r_cfg.stance_gain <= i_cfg_wdata;
                CFG_VEL_GAIN:  r_cfg.vel_gain    <= i_cfg_wdata;
                CFG_CENT_GAIN: r_cfg.cent_gain   <= i_cfg_wdata;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Pipeline control: all arithmetic stages advance together and only stall
    // when the last stage holds an item that the serializer cannot take yet.
    logic w_en;
    logic w_s2_valid, w_s4_valid, w_take;
    t_s2  w_s2;
    t_s4  w_s4;

    assign w_en          = !w_s4_valid || w_take;
    assign s_axis_tready = w_en;

    // Stages one and two: products, rotation matrix, cross product
    rfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_valid (w_s2_valid),
        .o_s2    (w_s2)
    );

    // Stages three and four: hip offsets per foot, symmetry and centrifugal terms
    rfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s2_valid),
        .i_s2    (w_s2),
        .i_cfg   (r_cfg),
        .o_valid (w_s4_valid),
        .o_s4    (w_s4)
    );

    // Hold one item and emit its four feet through the output register
    rfp_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s4_valid),
        .i_s4     (w_s4),
        .o_take   (w_take),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

    // A taken non-final foot is followed at once by the next foot of the item
    `RFP_ASSERT_NEXT(a_foot_seq, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1), "foot sequence broken")

    // The end marker travels only with the final foot
    `RFP_ASSERT_NOW(a_last_foot, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == LAST_FOOT), "tlast not on final foot")

    // A stalled last arithmetic stage keeps its item
    `RFP_ASSERT_NEXT(a_s4_hold, w_s4_valid && !w_take, w_s4_valid && $stable(w_s4), "stage four item lost on stall")

    // Writes to unused indexes leave configuration untouched
    `RFP_ASSERT_NEXT(a_cfg_ignore, i_cfg_we && (i_cfg_idx > CFG_CENT_GAIN), $stable(r_cfg), "unused config index changed state")

endmodule
